// File: hdl/ilt_pkg.sv
// ----------------------------------------------------------------------------
// ilt_pkg
// Shared types and codes of the indentation level tracker.
// ----------------------------------------------------------------------------
package ilt_pkg;

   localparam int LEVEL_W   = 8;
   localparam int LEVEL_MAX = 255;
   localparam int FUNC_W    = 2;
   localparam int KIND_W    = 3;
   localparam int OPEN_W    = 5;
   localparam int OP_W      = 2;
   localparam int CMDQ_DEPTH = 2;

   // item function codes
   localparam logic [FUNC_W-1:0] FUNC_WS      = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_CONTENT = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_BLANK   = 2'd2;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_SAME      = 3'd0;
   localparam logic [KIND_W-1:0] KIND_INDENT    = 3'd1;
   localparam logic [KIND_W-1:0] KIND_DEDENT    = 3'd2;
   localparam logic [KIND_W-1:0] KIND_UNMATCHED = 3'd3;
   localparam logic [KIND_W-1:0] KIND_TABERR    = 3'd4;
   localparam logic [KIND_W-1:0] KIND_OVERFLOW  = 3'd5;
   localparam logic [KIND_W-1:0] KIND_HALTED    = 3'd6;

   // commands from front to back
   localparam logic [OP_W-1:0] OP_NOP    = 2'd0;  // result only when halted
   localparam logic [OP_W-1:0] OP_TABERR = 2'd1;
   localparam logic [OP_W-1:0] OP_LINE   = 2'd2;  // compare level with stack

   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [LEVEL_W-1:0] level;
   } cmd_type;

   typedef struct packed {
      logic [KIND_W-1:0] token_kind;
      logic              last;
      logic [OPEN_W-1:0] open_levels;
   } rsp_type;

endpackage

// File: hdl/indentation_level_tracker.sv
// ----------------------------------------------------------------------------
// indentation_level_tracker
// Offside-rule indent/dedent generator over a stream of line-start items.
// ----------------------------------------------------------------------------
// Usage:
//  - Items go in on req_* (push/full). func 0 is one leading whitespace
//    character (req_is_tab picks tab or space), func 1 the first content
//    character of a line, func 2 the end of a blank or comment line.
//  - Results come out on rsp_* (empty/pop): kind, last-of-line flag, open
//    levels. Whitespace and blank lines give only halted or tab-error results.
//  - csr_we/csr_wdata set strict tab mode; write only while the block is idle.
//  - The front classifies an item in the cycle it is taken and pushes one
//    command into a two-entry queue; the back works through them in order.
//    A line end's command is registered in the queue, and its result in the
//    back's result register, before it shows on rsp_*. A dedent of N levels
//    pops the stack one level at a time (one stack memory read per level),
//    then makes a final compare and gives N results, one per popped level.
//  - When rsp_pop stays low the back stalls on its result register, the
//    command queue fills and req_full rises; nothing is dropped.
//  - Reset clears the stack count, the halt flag, the line measure and
//    strict mode. After any error every item returns a halted result until
//    the next reset.
// ----------------------------------------------------------------------------
module indentation_level_tracker #(
   parameter int TAB_WIDTH   = 8,
   parameter int STACK_DEPTH = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   // input items
   input  logic                         req_push,
   output logic                         req_full,
   input  logic [ilt_pkg::FUNC_W-1:0]   req_func,
   input  logic                         req_is_tab,
   // results
   output logic                         rsp_empty,
   input  logic                         rsp_pop,
   output logic [ilt_pkg::KIND_W-1:0]   rsp_token_kind,
   output logic                         rsp_last,
   output logic [ilt_pkg::OPEN_W-1:0]   rsp_open_levels,
   // configuration
   input  logic                         csr_we,
   input  logic                         csr_wdata
);

   logic             cmdq_full;
   logic             cmd_push;
   ilt_pkg::cmd_type cmd_in;
   logic             cmd_pop;
   ilt_pkg::cmd_type cmd_out;
   logic             cmd_valid;
   ilt_pkg::rsp_type rsp;

   assign req_full = cmdq_full;

   // Front: whitespace measure and line classification.
   ilt_front #(
      .TAB_WIDTH (TAB_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_func   (req_func),
      .req_is_tab (req_is_tab),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .cmdq_full  (cmdq_full),
      .cmd_push   (cmd_push),
      .cmd        (cmd_in)
   );

   // Decouples the two halves so each can stall on its own.
   ilt_cmdq u_cmdq (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .din       (cmd_in),
      .full      (cmdq_full),
      .pop       (cmd_pop),
      .dout      (cmd_out),
      .not_empty (cmd_valid)
   );

   // Back: level stack, dedent runs, errors and the result register.
   ilt_back #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd_out),
      .cmd_pop   (cmd_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp       (rsp)
   );

   assign rsp_token_kind  = rsp.token_kind;
   assign rsp_last        = rsp.last;
   assign rsp_open_levels = rsp.open_levels;

endmodule

// File: hdl/ilt_front.sv
// ----------------------------------------------------------------------------
// ilt_front
// Measures leading whitespace and turns every item into a command.
// ----------------------------------------------------------------------------
module ilt_front #(
   parameter int TAB_WIDTH = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_push,
   input  logic [ilt_pkg::FUNC_W-1:0]   req_func,
   input  logic                         req_is_tab,
   input  logic                         csr_we,
   input  logic                         csr_wdata,
   input  logic                         cmdq_full,
   output logic                         cmd_push,
   output ilt_pkg::cmd_type             cmd
);

   localparam int LW      = ilt_pkg::LEVEL_W;
   localparam int CLW     = $clog2(TAB_WIDTH + 1);
   localparam int SAT_COL = ilt_pkg::LEVEL_MAX % TAB_WIDTH;

   logic           strict_ff;
   logic [LW-1:0]  level_ff,    level_in;
   logic [CLW-1:0] col_ff,      col_in;      // level modulo tab width
   logic           has_ws_ff,   has_ws_in;
   logic           began_sp_ff, began_sp_in;
   logic           mix_ff,      mix_in;

   logic           began_sp;
   logic [LW:0]    add;
   logic [LW:0]    sum;
   logic [CLW-1:0] col_inc;

   assign cmd_push = req_push & ~cmdq_full;

   always_comb begin
      began_sp = has_ws_ff ? began_sp_ff : ~req_is_tab;
      if (!req_is_tab) begin
         add = (LW+1)'(1);
      end else if (strict_ff) begin
         add = (LW+1)'(TAB_WIDTH);
      end else begin
         add = (LW+1)'(TAB_WIDTH) - (LW+1)'(col_ff);
      end
      sum     = {1'b0, level_ff} + add;
      col_inc = col_ff + CLW'(1);

      level_in    = level_ff;
      col_in      = col_ff;
      has_ws_in   = has_ws_ff;
      began_sp_in = began_sp_ff;
      mix_in      = mix_ff;
      cmd.op      = ilt_pkg::OP_NOP;
      cmd.level   = level_ff;

      if (cmd_push) begin
         case (req_func)
            ilt_pkg::FUNC_WS: begin
               has_ws_in   = 1'b1;
               began_sp_in = began_sp;
               if (req_is_tab && strict_ff && began_sp) begin
                  mix_in = 1'b1;
               end
               if (sum > (LW+1)'(ilt_pkg::LEVEL_MAX)) begin
                  level_in = LW'(ilt_pkg::LEVEL_MAX);
                  col_in   = CLW'(SAT_COL);
               end else begin
                  level_in = sum[LW-1:0];
                  if (!req_is_tab) begin
                     col_in = (col_inc == CLW'(TAB_WIDTH)) ? '0 : col_inc;
                  end else if (!strict_ff) begin
                     col_in = '0;
                  end
               end
            end
            ilt_pkg::FUNC_CONTENT, ilt_pkg::FUNC_BLANK: begin
               level_in    = '0;
               col_in      = '0;
               has_ws_in   = 1'b0;
               began_sp_in = 1'b0;
               mix_in      = 1'b0;
               if (mix_ff) begin
                  cmd.op = ilt_pkg::OP_TABERR;
               end else if (req_func == ilt_pkg::FUNC_CONTENT) begin
                  cmd.op = ilt_pkg::OP_LINE;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strict_ff   <= 1'b0;
         level_ff    <= '0;
         col_ff      <= '0;
         has_ws_ff   <= 1'b0;
         began_sp_ff <= 1'b0;
         mix_ff      <= 1'b0;
      end else begin
         if (csr_we) begin
            strict_ff <= csr_wdata;
         end
         level_ff    <= level_in;
         col_ff      <= col_in;
         has_ws_ff   <= has_ws_in;
         began_sp_ff <= began_sp_in;
         mix_ff      <= mix_in;
      end
   end

endmodule

// File: hdl/ilt_cmdq.sv
// ----------------------------------------------------------------------------
// ilt_cmdq
// Two-entry command queue between front and back.
// ----------------------------------------------------------------------------
module ilt_cmdq (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  ilt_pkg::cmd_type din,
   output logic             full,
   input  logic             pop,
   output ilt_pkg::cmd_type dout,
   output logic             not_empty
);

   localparam int DEPTH = ilt_pkg::CMDQ_DEPTH;
   localparam int PW    = $clog2(DEPTH);
   localparam int NW    = $clog2(DEPTH + 1);

   ilt_pkg::cmd_type entry_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]    fill_ff,   fill_in;
   logic             do_push, do_pop;

   assign full      = (fill_ff == NW'(DEPTH));
   assign not_empty = (fill_ff != '0);
   assign dout      = entry_ff[rd_ptr_ff];
   assign do_push   = push & ~full;
   assign do_pop    = pop & not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + NW'(1);
      end else if (!do_push && do_pop) begin
         fill_in = fill_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

// File: hdl/ilt_back.sv
// ----------------------------------------------------------------------------
// ilt_back
// Level stack, dedent scan and result register.
// ----------------------------------------------------------------------------
module ilt_back #(
   parameter int STACK_DEPTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   input  ilt_pkg::cmd_type cmd,
   output logic             cmd_pop,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output ilt_pkg::rsp_type rsp
);

   localparam int LW = ilt_pkg::LEVEL_W;
   localparam int OW = ilt_pkg::OPEN_W;
   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int AW = $clog2(STACK_DEPTH);

   localparam logic [1:0] B_IDLE = 2'd0;
   localparam logic [1:0] B_SCAN = 2'd1;  // popping while level below top
   localparam logic [1:0] B_EMIT = 2'd2;  // one dedent result per free cycle

   logic [LW-1:0] level_stack [STACK_DEPTH];

   logic [1:0]    state_ff,  state_in;
   logic [CW-1:0] count_ff,  count_in;
   logic [LW-1:0] top_ff,    top_in;
   logic [LW-1:0] lvl_ff,    lvl_in;
   logic [CW-1:0] saved_ff,  saved_in;
   logic [CW-1:0] ecnt_ff,   ecnt_in;
   logic          halted_ff, halted_in;
   logic          out_valid_ff;
   ilt_pkg::rsp_type out_ff;
   logic [LW-1:0] rd_data_ff;

   logic          out_free;
   logic          emit;
   ilt_pkg::rsp_type emit_rsp;
   logic          wr_en;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic [LW-1:0] top_now;

   assign out_free  = ~out_valid_ff | rsp_pop;
   assign rsp_empty = ~out_valid_ff;
   assign rsp       = out_ff;
   assign rd_addr   = AW'(count_ff - CW'(2));
   assign top_now   = (count_ff == '0) ? '0 : rd_data_ff;

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      top_in    = top_ff;
      lvl_in    = lvl_ff;
      saved_in  = saved_ff;
      ecnt_in   = ecnt_ff;
      halted_in = halted_ff;
      cmd_pop   = 1'b0;
      emit      = 1'b0;
      wr_en     = 1'b0;
      rd_en     = 1'b0;
      emit_rsp.token_kind  = ilt_pkg::KIND_SAME;
      emit_rsp.last        = 1'b1;
      emit_rsp.open_levels = OW'(count_ff);

      case (state_ff)
         B_IDLE: begin
            if (cmd_valid) begin
               if (halted_ff) begin
                  if (out_free) begin
                     cmd_pop = 1'b1;
                     emit    = 1'b1;
                     emit_rsp.token_kind = ilt_pkg::KIND_HALTED;
                  end
               end else begin
                  case (cmd.op)
                     ilt_pkg::OP_TABERR: begin
                        if (out_free) begin
                           cmd_pop   = 1'b1;
                           emit      = 1'b1;
                           halted_in = 1'b1;
                           emit_rsp.token_kind = ilt_pkg::KIND_TABERR;
                        end
                     end
                     ilt_pkg::OP_LINE: begin
                        if (cmd.level == top_ff) begin
                           if (out_free) begin
                              cmd_pop = 1'b1;
                              emit    = 1'b1;
                           end
                        end else if (cmd.level > top_ff) begin
                           if (out_free) begin
                              cmd_pop = 1'b1;
                              emit    = 1'b1;
                              if (count_ff == CW'(STACK_DEPTH)) begin
                                 halted_in = 1'b1;
                                 emit_rsp.token_kind = ilt_pkg::KIND_OVERFLOW;
                              end else begin
                                 wr_en    = 1'b1;
                                 count_in = count_ff + CW'(1);
                                 top_in   = cmd.level;
                                 emit_rsp.token_kind  = ilt_pkg::KIND_INDENT;
                                 emit_rsp.open_levels = OW'(count_ff + CW'(1));
                              end
                           end
                        end else begin
                           // dedent: pop the top now, read the entry below it
                           cmd_pop  = 1'b1;
                           lvl_in   = cmd.level;
                           saved_in = count_ff;
                           count_in = count_ff - CW'(1);
                           rd_en    = 1'b1;
                           state_in = B_SCAN;
                        end
                     end
                     default: begin
                        cmd_pop = 1'b1;
                     end
                  endcase
               end
            end
         end
         B_SCAN: begin
            if ((count_ff != '0) && (lvl_ff < top_now)) begin
               count_in = count_ff - CW'(1);
               rd_en    = 1'b1;
            end else if (lvl_ff == top_now) begin
               top_in   = top_now;
               ecnt_in  = saved_ff - CW'(1);
               state_in = B_EMIT;
            end else if (out_free) begin
               top_in    = top_now;
               emit      = 1'b1;
               halted_in = 1'b1;
               state_in  = B_IDLE;
               emit_rsp.token_kind = ilt_pkg::KIND_UNMATCHED;
            end
         end
         B_EMIT: begin
            if (out_free) begin
               emit = 1'b1;
               emit_rsp.token_kind  = ilt_pkg::KIND_DEDENT;
               emit_rsp.open_levels = OW'(ecnt_ff);
               emit_rsp.last        = (ecnt_ff == count_ff);
               if (ecnt_ff == count_ff) begin
                  state_in = B_IDLE;
               end else begin
                  ecnt_in = ecnt_ff - CW'(1);
               end
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         count_ff     <= '0;
         top_ff       <= '0;
         halted_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         top_ff    <= top_in;
         halted_ff <= halted_in;
         if (emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      lvl_ff   <= lvl_in;
      saved_ff <= saved_in;
      ecnt_ff  <= ecnt_in;
      if (emit) begin
         out_ff <= emit_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         level_stack[count_ff[AW-1:0]] <= cmd.level;
      end
      if (rd_en) begin
         rd_data_ff <= level_stack[rd_addr];
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(STACK_DEPTH))
      else $error("level stack count above depth");

   a_halt_sticks: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff)
      else $error("halt cleared without reset");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_pop) |-> !emit)
      else $error("pending result overwritten");

   a_emit_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_EMIT) |-> (ecnt_ff >= count_ff && ecnt_ff < saved_ff))
      else $error("dedent counter out of range");

   a_scan_from_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_IDLE && state_in == B_SCAN) |=> (count_ff == saved_ff - CW'(1)))
      else $error("dedent scan did not pop the top level");
`endif

endmodule

// File: sim/indentation_level_tracker_test.sv
// ----------------------------------------------------------------------------
// indentation_level_tracker_test
// Self-checking bench for the offside-rule indent/dedent tracker.
// ----------------------------------------------------------------------------
// Lines are built as runs of whitespace items closed by a content or blank
// item. A small planner shapes them so that most lines land on an open
// level. Every accepted item runs through an indentation tracker kept here,
// which lists the tokens the line should produce. Each token popped from the
// block is checked field by field against the oldest listed one. Both sides
// stall at random; the receiver holds off long enough for the input to back
// up early on, and rarely later. The run ends on one halting error, picked
// at random, followed by a few items that must all come back halted.
// ----------------------------------------------------------------------------
module indentation_level_tracker_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TAB_W         = 8;
   localparam int STACK_N       = 16;
   localparam int SETTLE_CYCLES = 2 * STACK_N + 20;  // longest dedent run + queue
   localparam int HOLD_CYCLES   = 200;
   localparam int STALL_LIMIT   = 3000;
   localparam int PHASE_ITEMS   = 25;

   typedef logic [ilt_pkg::FUNC_W-1:0] func_type;

   // func code 3 has no name in the package; the block ignores it until halted
   localparam func_type FUNC_IGNORED = 2'd3;

   typedef struct {
      func_type func;
      logic     tab;
   } char_item_type;

   // ------------------------------------------------------------------
   // block ports, inputs known from time zero
   // ------------------------------------------------------------------
   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_push = 1'b0;
   logic                         req_full;
   func_type                     req_func = ilt_pkg::FUNC_WS;
   logic                         req_is_tab = 1'b0;
   logic                         rsp_empty;
   logic                         rsp_pop = 1'b0;
   logic [ilt_pkg::KIND_W-1:0]   rsp_token_kind;
   logic                         rsp_last;
   logic [ilt_pkg::OPEN_W-1:0]   rsp_open_levels;
   logic                         csr_we = 1'b0;
   logic                         csr_wdata = 1'b0;

   indentation_level_tracker #(
      .TAB_WIDTH   (TAB_W),
      .STACK_DEPTH (STACK_N)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_func        (req_func),
      .req_is_tab      (req_is_tab),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_token_kind  (rsp_token_kind),
      .rsp_last        (rsp_last),
      .rsp_open_levels (rsp_open_levels),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // tracker state as the block should hold it
   // ------------------------------------------------------------------
   logic [ilt_pkg::LEVEL_W-1:0] open_stack [STACK_N];
   int                 depth_count = 0;
   int                 line_level = 0;
   bit                 line_space_first = 1'b0;
   bit                 line_has_ws = 1'b0;
   bit                 tab_mixed = 1'b0;
   bit                 halted = 1'b0;
   bit                 strict_mode = 1'b0;

   ilt_pkg::rsp_type expected_tokens[$];
   char_item_type    pending_chars[$];
   int         plan_open[$];      // levels the line planner believes are open
   int         planned_count = 0; // items queued, func 3 noise not counted
   int         error_count = 0;
   int         results_seen = 0;

   // handshake pacing
   int send_wait = 0;
   bit send_steady = 1'b0;
   int take_wait = 0;
   bit take_steady = 1'b0;
   int hold_left = 0;
   int stall_cycles = 0;

   function automatic int clamp_level(input int v);
      return (v > ilt_pkg::LEVEL_MAX) ? ilt_pkg::LEVEL_MAX : v;
   endfunction

   function automatic int open_top();
      return (depth_count == 0) ? 0 : int'(open_stack[depth_count-1]);
   endfunction

   task automatic expect_token(input logic [ilt_pkg::KIND_W-1:0] kind, input logic fin,
                               input int open_cnt);
      ilt_pkg::rsp_type tok;
      tok.token_kind  = kind;
      tok.last        = fin;
      tok.open_levels = open_cnt[ilt_pkg::OPEN_W-1:0];
      expected_tokens.insert(expected_tokens.size(), tok);
   endtask

   task automatic clear_line();
      line_level       = 0;
      line_space_first = 1'b0;
      line_has_ws      = 1'b0;
      tab_mixed        = 1'b0;
   endtask

   // One accepted item in, the tokens it causes appended to expected_tokens.
   task automatic track_indentation(input func_type func, input logic tab);
      int lvl;
      int saved;
      int pops;
      lvl   = 0;
      saved = 0;
      pops  = 0;
      if (halted) begin
         expect_token(ilt_pkg::KIND_HALTED, 1'b1, depth_count);
      end else if (func == ilt_pkg::FUNC_WS) begin
         if (!line_has_ws) begin
            line_has_ws      = 1'b1;
            line_space_first = !tab;
         end
         if (!tab) begin
            line_level = clamp_level(line_level + 1);
         end else if (strict_mode) begin
            line_level = clamp_level(line_level + TAB_W);
            if (line_space_first) tab_mixed = 1'b1;
         end else begin
            // advance to the next tab stop
            line_level = clamp_level(line_level + TAB_W - line_level % TAB_W);
         end
      end else if (func == FUNC_IGNORED) begin
         // no effect while running
      end else if (tab_mixed) begin
         // reported at line end, content or blank alike
         clear_line();
         halted = 1'b1;
         expect_token(ilt_pkg::KIND_TABERR, 1'b1, depth_count);
      end else if (func == ilt_pkg::FUNC_BLANK) begin
         clear_line();
      end else begin
         lvl = line_level;
         clear_line();
         if (lvl == open_top()) begin
            expect_token(ilt_pkg::KIND_SAME, 1'b1, depth_count);
         end else if (lvl > open_top()) begin
            if (depth_count >= STACK_N) begin
               halted = 1'b1;
               expect_token(ilt_pkg::KIND_OVERFLOW, 1'b1, depth_count);
            end else begin
               open_stack[depth_count] = lvl[ilt_pkg::LEVEL_W-1:0];
               depth_count++;
               expect_token(ilt_pkg::KIND_INDENT, 1'b1, depth_count);
            end
         end else begin
            saved = depth_count;
            while (depth_count > 0 && lvl < open_top()) begin
               depth_count--;
               pops++;
            end
            if (lvl != open_top()) begin
               // popped levels stay popped
               halted = 1'b1;
               expect_token(ilt_pkg::KIND_UNMATCHED, 1'b1, depth_count);
            end else begin
               for (int i = 0; i < pops; i++)
                  expect_token(ilt_pkg::KIND_DEDENT, (i + 1 == pops), saved - i - 1);
            end
         end
      end
   endtask

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      error_count++;
   endtask

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // ------------------------------------------------------------------
   // line planner: fills pending_chars
   // ------------------------------------------------------------------
   task automatic queue_char(input func_type func, input logic tab);
      char_item_type c;
      c.func = func;
      c.tab  = tab;
      pending_chars.insert(pending_chars.size(), c);
      if (func != FUNC_IGNORED) planned_count++;
   endtask

   task automatic plan_note(input int level);
      int top;
      top = (plan_open.size() == 0) ? 0 : plan_open[$];
      if (level > top) begin
         plan_open.insert(plan_open.size(), level);
      end else begin
         while (plan_open.size() > 0 && level < plan_open[$])
            plan_open.delete(plan_open.size() - 1);
      end
   endtask

   // Whitespace that measures exactly target; strict mode never gets a tab
   // after a leading space here.
   task automatic queue_whitespace(input int target);
      int  lvl;
      int  step;
      bit  space_first;
      bit  any_ws;
      lvl         = 0;
      space_first = 1'b0;
      any_ws      = 1'b0;
      while (lvl < target) begin
         if ($urandom_range(0, 19) == 0) queue_char(FUNC_IGNORED, 1'($urandom_range(0, 1)));
         step = strict_mode ? TAB_W : TAB_W - lvl % TAB_W;
         if (!(strict_mode && space_first) && step <= target - lvl &&
             $urandom_range(0, 2) != 0) begin
            queue_char(ilt_pkg::FUNC_WS, 1'b1);
            lvl += step;
         end else begin
            queue_char(ilt_pkg::FUNC_WS, 1'b0);
            if (!any_ws) space_first = 1'b1;
            lvl++;
         end
         any_ws = 1'b1;
      end
   endtask

   task automatic queue_line(input int target, input bit blank);
      queue_whitespace(target);
      queue_char(blank ? ilt_pkg::FUNC_BLANK : ilt_pkg::FUNC_CONTENT,
                 1'($urandom_range(0, 1)));
      if (!blank) plan_note(target);
   endtask

   task automatic queue_random_line();
      int r;
      int depth;
      int top;
      int j;
      depth = plan_open.size();
      top   = (depth == 0) ? 0 : plan_open[$];
      r     = $urandom_range(0, 99);
      if (r < 10) begin
         queue_line($urandom_range(0, 20), 1'b1);
      end else if (r < 15) begin
         queue_char(FUNC_IGNORED, 1'($urandom_range(0, 1)));
      end else if (r < 35) begin
         queue_line(top, 1'b0);
      end else if (r < 68 && depth < STACK_N && top < 240) begin
         queue_line(top + $urandom_range(1, 12), 1'b0);
      end else if (depth > 0) begin
         // mostly one level back, sometimes a deeper run
         j = ($urandom_range(0, 3) == 0) ? $urandom_range(0, depth - 1) : depth - 1;
         queue_line((j == 0) ? 0 : plan_open[j-1], 1'b0);
      end else begin
         queue_line(top, 1'b0);
      end
   endtask

   // ------------------------------------------------------------------
   // phase control
   // ------------------------------------------------------------------
   task automatic wait_idle();
      do @(negedge clock); while (pending_chars.size() > 0 || req_push);
      while (expected_tokens.size() > 0) @(negedge clock);
      // a trailing whitespace item can still be in the back end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_strict(input bit v);
      @(posedge clock);
      csr_we      <= 1'b1;
      csr_wdata   <= v;
      strict_mode = v;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic run_random_phase(input bit strict);
      int start;
      write_strict(strict);
      start = planned_count;
      while (planned_count - start < PHASE_ITEMS) queue_random_line();
      wait_idle();
   endtask

   // ------------------------------------------------------------------
   // sender: offers queued items, holds one while full is high
   // ------------------------------------------------------------------
   always @(posedge clock) begin : feed_proc
      char_item_type next_char;
      if (reset) begin
         req_push  <= 1'b0;
         send_wait = 0;
      end else begin
         if (req_push && !req_full) begin
            track_indentation(req_func, req_is_tab);
            if ($urandom_range(0, 49) == 0) send_steady = !send_steady;
            // keep pushing while the receiver holds off so the block backs up
            send_wait = (send_steady || hold_left > 0) ? 0 : pick_gap();
         end
         if (req_push && req_full) begin
            // item still on offer
         end else if (send_wait > 0) begin
            send_wait--;
            req_push <= 1'b0;
         end else if (pending_chars.size() > 0) begin
            next_char = pending_chars.pop_front();
            req_push   <= 1'b1;
            req_func   <= next_char.func;
            req_is_tab <= next_char.tab;
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // receiver: pops tokens and checks them in order
   // ------------------------------------------------------------------
   always @(posedge clock) begin : check_proc
      ilt_pkg::rsp_type want;
      if (reset) begin
         rsp_pop   <= 1'b0;
         take_wait = 0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            results_seen++;
            if (expected_tokens.size() == 0) begin
               report_mismatch($sformatf("unexpected token kind %0d last %0d open %0d",
                                         rsp_token_kind, rsp_last, rsp_open_levels));
            end else begin
               want = expected_tokens.pop_front();
               if (rsp_token_kind !== want.token_kind)
                  report_mismatch($sformatf("token_kind %0d, want %0d",
                                            rsp_token_kind, want.token_kind));
               if (rsp_last !== want.last)
                  report_mismatch($sformatf("last %0d, want %0d", rsp_last, want.last));
               if (rsp_open_levels !== want.open_levels)
                  report_mismatch($sformatf("open_levels %0d, want %0d",
                                            rsp_open_levels, want.open_levels));
            end
            // one early long hold while the deep push is under way, rare ones later
            if (results_seen == 8 || $urandom_range(0, 399) == 0) hold_left = HOLD_CYCLES;
            if ($urandom_range(0, 49) == 0) take_steady = !take_steady;
            take_wait = take_steady ? 0 : pick_gap();
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else if (take_wait > 0) begin
            take_wait--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------
   // watchdog: too long without any handshake on either side
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles == STALL_LIMIT) begin
            $display("[%0t] no handshake for %0d cycles", $realtime, STALL_LIMIT);
            $display("status: fail");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------
   initial begin
      int err_pick;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed, relaxed tabs
      write_strict(1'b0);
      queue_line(0, 1'b0);                    // same level at the bottom
      queue_line(5, 1'b1);                    // blank line with whitespace
      queue_char(ilt_pkg::FUNC_BLANK, 1'b1);  // bare blank line
      queue_char(FUNC_IGNORED, 1'b1);
      queue_char(FUNC_IGNORED, 1'b0);
      // spaces then a tab round up to the tab stop
      repeat (3) queue_char(ilt_pkg::FUNC_WS, 1'b0);
      queue_char(ilt_pkg::FUNC_WS, 1'b1);
      queue_char(ilt_pkg::FUNC_CONTENT, 1'b1);
      plan_note(TAB_W);
      // fill the stack, then one dedent run of full depth
      for (int k = 1; k < STACK_N; k++) queue_line(TAB_W + k, 1'b0);
      queue_line(0, 1'b0);
      // level saturates at the top of its range
      repeat (33) queue_char(ilt_pkg::FUNC_WS, 1'b1);
      queue_char(ilt_pkg::FUNC_CONTENT, 1'b0);
      plan_note(ilt_pkg::LEVEL_MAX);
      repeat (3) queue_char(ilt_pkg::FUNC_WS, 1'b0);
      repeat (32) queue_char(ilt_pkg::FUNC_WS, 1'b1);
      queue_char(ilt_pkg::FUNC_CONTENT, 1'b1);
      queue_line(0, 1'b0);
      wait_idle();

      run_random_phase(1'b1);
      run_random_phase(1'b0);
      run_random_phase(1'b1);

      // one halting error per run, strict mode still set
      err_pick = $urandom_range(0, 3);
      case (err_pick)
         0, 1: begin
            // tab after a leading space, caught at content or blank end
            queue_char(ilt_pkg::FUNC_WS, 1'b0);
            queue_char(ilt_pkg::FUNC_WS, 1'b1);
            queue_char(ilt_pkg::FUNC_WS, 1'($urandom_range(0, 1)));
            queue_char((err_pick == 0) ? ilt_pkg::FUNC_CONTENT : ilt_pkg::FUNC_BLANK,
                       1'($urandom_range(0, 1)));
         end
         2: begin
            // dedent to a level that was never open
            queue_line(0, 1'b0);
            queue_line(4, 1'b0);
            queue_line(2, 1'b0);
         end
         default: begin
            // one push past a full stack
            queue_line(0, 1'b0);
            for (int k = 1; k <= STACK_N + 1; k++) queue_line(k, 1'b0);
         end
      endcase
      // everything after the error comes back halted
      repeat (6) queue_char(func_type'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
      wait_idle();

      if (error_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// File: files.f
hdl/ilt_pkg.sv
hdl/ilt_front.sv
hdl/ilt_cmdq.sv
hdl/ilt_back.sv
hdl/indentation_level_tracker.sv
sim/indentation_level_tracker_test.sv
